// File: hdl/rbd_pkg.sv
`default_nettype none

package rbd_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned DATA_WIDTH  = 32;
  localparam int unsigned ADDR_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_OUT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_READ       = 3'd4,
    CMD_INSERT     = 3'd5,
    CMD_ERASE      = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SH_RD,
    S_SH_WR,
    S_FIN,
    S_FETCH,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic sh_rd;
    logic sh_wr;
    logic fin;
    logic fetch;
    logic load_out;
  } ctrl_t;

  typedef struct packed {
    logic shift_start;
    logic shift_none;
    logic shift_last;
    logic out_free;
  } stat_t;

  function automatic logic [ADDR_W-1:0] phys(logic [ADDR_W-1:0] head,
                                             logic [CNT_W-1:0]  x);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(head) + (CNT_W + 1)'(x);
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/rbd_ram.sv
`default_nettype none

module rbd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// File: hdl/rbd_ctrl.sv
`default_nettype none

module rbd_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire rbd_pkg::stat_t stat_i,
  output logic                in_ready_o,
  output rbd_pkg::ctrl_t      ctrl_o
);

  import rbd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.accept = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl_o.exec = 1'b1;
        if (stat_i.shift_start) begin
          state_d = stat_i.shift_none ? S_FIN : S_SH_RD;
        end else begin
          state_d = S_FETCH;
        end
      end
      S_SH_RD: begin
        ctrl_o.sh_rd = 1'b1;
        state_d      = S_SH_WR;
      end
      S_SH_WR: begin
        ctrl_o.sh_wr = 1'b1;
        state_d      = stat_i.shift_last ? S_FIN : S_SH_RD;
      end
      S_FIN: begin
        ctrl_o.fin = 1'b1;
        state_d    = S_FETCH;
      end
      S_FETCH: begin
        ctrl_o.fetch = 1'b1;
        state_d      = S_RESULT;
      end
      S_RESULT: begin
        if (stat_i.out_free) begin
          ctrl_o.load_out = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/rbd_datapath.sv
`default_nettype none

module rbd_datapath (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic        [rbd_pkg::CMD_W-1:0]       command_i,
  input  wire logic signed [rbd_pkg::FIELD_W-1:0]     data_in_i,
  input  wire logic        [rbd_pkg::POS_W-1:0]       position_i,
  input  wire logic                                   out_ready_i,
  input  wire rbd_pkg::ctrl_t                         ctrl_i,
  output rbd_pkg::stat_t                              stat_o,
  output logic                                        out_valid_o,
  output logic             [rbd_pkg::STATUS_W-1:0]    status_o,
  output logic signed      [rbd_pkg::FIELD_W-1:0]     read_data_o,
  output logic signed      [rbd_pkg::FIELD_W-1:0]     front_value_o,
  output logic signed      [rbd_pkg::FIELD_W-1:0]     back_value_o,
  output logic             [rbd_pkg::COUNT_OUT_W-1:0] entry_count_o,
  output logic                                        is_empty_o
);

  import rbd_pkg::*;

  cmd_e                  cmd_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [POS_W-1:0]      pos_q;
  logic [ADDR_W-1:0]     head_q;
  logic [CNT_W-1:0]      count_q;
  logic [CNT_W-1:0]      k_q;
  status_e               status_q;
  logic [DATA_WIDTH-1:0] rd_q;

  status_e               st_code;
  logic [ADDR_W-1:0]     head_dec;
  logic [CNT_W-1:0]      pos_c;
  logic                  is_insert;
  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [ADDR_W-1:0]     raddr_a;
  logic [ADDR_W-1:0]     raddr_b;
  logic [DATA_WIDTH-1:0] rdata_a;
  logic [DATA_WIDTH-1:0] rdata_b;

  assign pos_c     = CNT_W'(pos_q);
  assign is_insert = (cmd_q == CMD_INSERT);
  assign head_dec  = (head_q == '0) ? ADDR_W'(DEPTH - 1) : head_q - 1'b1;

  always_comb begin
    st_code = ST_OK;
    unique case (cmd_q)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (32'(count_q) >= DEPTH) st_code = ST_FULL;
      end
      CMD_POP_BACK, CMD_POP_FRONT: begin
        if (count_q == '0) st_code = ST_EMPTY;
      end
      CMD_READ, CMD_ERASE: begin
        if (count_q == '0) begin
          st_code = ST_EMPTY;
        end else if (32'(pos_q) >= 32'(count_q)) begin
          st_code = ST_RANGE;
        end
      end
      CMD_INSERT: begin
        if (32'(pos_q) > 32'(count_q)) begin
          st_code = ST_RANGE;
        end else if (32'(count_q) >= DEPTH) begin
          st_code = ST_FULL;
        end
      end
      CMD_CLEAR: begin
        st_code = ST_OK;
      end
    endcase
  end

  always_comb begin
    stat_o.shift_start = (st_code == ST_OK) && (is_insert || cmd_q == CMD_ERASE);
    stat_o.shift_none  = is_insert ? (32'(count_q) == 32'(pos_q))
                                   : (32'(pos_q) + 32'd1 >= 32'(count_q));
    stat_o.shift_last  = is_insert ? (32'(k_q) == 32'(pos_q) + 32'd1)
                                   : (32'(k_q) + 32'd2 >= 32'(count_q));
    stat_o.out_free    = !out_valid_o || out_ready_i;
  end

  always_comb begin
    we    = 1'b0;
    waddr = phys(head_q, count_q);
    wdata = data_q;
    if (ctrl_i.exec && st_code == ST_OK && cmd_q == CMD_PUSH_BACK) begin
      we = 1'b1;
    end else if (ctrl_i.exec && st_code == ST_OK && cmd_q == CMD_PUSH_FRONT) begin
      we    = 1'b1;
      waddr = head_dec;
    end else if (ctrl_i.sh_wr) begin
      we    = 1'b1;
      waddr = phys(head_q, k_q);
      wdata = rdata_a;
    end else if (ctrl_i.fin && is_insert) begin
      we    = 1'b1;
      waddr = phys(head_q, pos_c);
    end
  end

  always_comb begin
    raddr_a = phys(head_q, '0);
    if (ctrl_i.exec) begin
      raddr_a = phys(head_q, pos_c);
    end else if (ctrl_i.sh_rd) begin
      raddr_a = is_insert ? phys(head_q, k_q - CNT_W'(1)) : phys(head_q, k_q + CNT_W'(1));
    end
    raddr_b = phys(head_q, count_q - CNT_W'(1));
  end

  rbd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q  <= cmd_e'(command_i);
      data_q <= DATA_WIDTH'(data_in_i);
      pos_q  <= position_i;
    end
    if (ctrl_i.exec) begin
      status_q <= st_code;
      k_q      <= is_insert ? count_q : pos_c;
    end else if (ctrl_i.sh_wr) begin
      k_q <= is_insert ? k_q - CNT_W'(1) : k_q + CNT_W'(1);
    end
    if (ctrl_i.fetch) begin
      rd_q <= (cmd_q == CMD_READ && status_q == ST_OK) ? rdata_a : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (ctrl_i.exec && st_code == ST_OK) begin
      unique case (cmd_q)
        CMD_PUSH_BACK: begin
          count_q <= count_q + CNT_W'(1);
        end
        CMD_PUSH_FRONT: begin
          head_q  <= head_dec;
          count_q <= count_q + CNT_W'(1);
        end
        CMD_POP_BACK: begin
          count_q <= count_q - CNT_W'(1);
        end
        CMD_POP_FRONT: begin
          head_q  <= phys(head_q, CNT_W'(1));
          count_q <= count_q - CNT_W'(1);
        end
        CMD_CLEAR: begin
          head_q  <= '0;
          count_q <= '0;
        end
        CMD_READ, CMD_INSERT, CMD_ERASE: begin
          head_q <= head_q;
        end
      endcase
    end else if (ctrl_i.fin) begin
      count_q <= is_insert ? count_q + CNT_W'(1) : count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (ctrl_i.load_out) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      status_o      <= status_q;
      read_data_o   <= FIELD_W'(rd_q);
      front_value_o <= (count_q != '0) ? FIELD_W'(rdata_a) : '0;
      back_value_o  <= (count_q != '0) ? FIELD_W'(rdata_b) : '0;
      entry_count_o <= COUNT_OUT_W'(count_q);
      is_empty_o    <= (count_q == '0);
    end
  end

endmodule

`default_nettype wire

// File: hdl/ring_buffer_deque.sv
// channel   signals                                    accepted when
// input     command_i data_in_i position_i             in_valid_i & in_ready_o
// output    status_o read_data_o front_value_o         out_valid_o & out_ready_i
//           back_value_o entry_count_o is_empty_o
//
// Push, pop, read and clear step through execute, fetch and result between acceptances.
// A valid insert or erase also moves up to 15 entries before a finish step:
// each move is a read then a write through the single write port of the store.
// The result register holds one finished transaction; the next input is taken meanwhile
// and waits in its last step until the output is drained.
// Reset empties the deque at once; the store contents are left as they are.
`default_nettype none

module ring_buffer_deque (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic        [rbd_pkg::CMD_W-1:0]       command_i,
  input  wire logic signed [rbd_pkg::FIELD_W-1:0]     data_in_i,
  input  wire logic        [rbd_pkg::POS_W-1:0]       position_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic             [rbd_pkg::STATUS_W-1:0]    status_o,
  output logic signed      [rbd_pkg::FIELD_W-1:0]     read_data_o,
  output logic signed      [rbd_pkg::FIELD_W-1:0]     front_value_o,
  output logic signed      [rbd_pkg::FIELD_W-1:0]     back_value_o,
  output logic             [rbd_pkg::COUNT_OUT_W-1:0] entry_count_o,
  output logic                                        is_empty_o
);

  import rbd_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  rbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  rbd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .command_i     (command_i),
    .data_in_i     (data_in_i),
    .position_i    (position_i),
    .out_ready_i   (out_ready_i),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .read_data_o   (read_data_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o)
  );

endmodule

`default_nettype wire

// File: hdl/rbd_checker.sv
`default_nettype none

module rbd_checker (
  input wire logic                                   clk_i,
  input wire logic                                   rst_ni,
  input wire logic                                   out_valid_o,
  input wire logic                                   out_ready_i,
  input wire logic        [rbd_pkg::STATUS_W-1:0]    status_o,
  input wire logic signed [rbd_pkg::FIELD_W-1:0]     read_data_o,
  input wire logic signed [rbd_pkg::FIELD_W-1:0]     front_value_o,
  input wire logic signed [rbd_pkg::FIELD_W-1:0]     back_value_o,
  input wire logic        [rbd_pkg::COUNT_OUT_W-1:0] entry_count_o,
  input wire logic                                   is_empty_o
);

  import rbd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(read_data_o) && $stable(front_value_o) && $stable(back_value_o)
      && $stable(entry_count_o))
    else $error("result changed while stalled");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> is_empty_o && entry_count_o == '0)
    else $error("empty status with entries held");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> 32'(entry_count_o) == DEPTH)
    else $error("full status below capacity");

  a_single_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_count_o == COUNT_OUT_W'(1) |-> front_value_o == back_value_o)
    else $error("front and back differ with one entry");

endmodule

bind ring_buffer_deque rbd_checker u_rbd_checker (.*);

`default_nettype wire
